// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/rse_pkg.sv =====
package rse_pkg;

	// Stack geometry and arithmetic width.
	localparam int STACK_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int OUT_VALUE_W = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);

	// Character codes seen by the tokenizer.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_PAREN    = 3'd1,
		ST_FEW      = 3'd2,
		ST_INVALID  = 3'd3,
		ST_DIV0     = 3'd4,
		ST_DEPTH    = 3'd5,
		ST_OVERFLOW = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV
	} state_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_expr;
	} text_beat_t;

	typedef struct packed {
		logic signed [OUT_VALUE_W-1:0] value;
		logic [2:0]                    status;
	} result_beat_t;

	// Whitespace separates tokens.
	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

endpackage

// ===== rtl/rse_stack_mem.sv =====
module rse_stack_mem #(
	parameter int Depth = 64,
	parameter int Width = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rse_divider.sv =====
module rse_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rse_pkg::VALUE_WIDTH-1:0] dividend,
	input  logic [rse_pkg::VALUE_WIDTH-1:0] divisor,
	output logic                            done,
	output logic [rse_pkg::VALUE_WIDTH-1:0] quotient
);

	localparam int W = rse_pkg::VALUE_WIDTH;

	logic                           busy_q;
	logic                           done_q;
	logic [rse_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [W:0]                     rem_q;
	logic [W-1:0]                   quo_q;
	logic [W-1:0]                   mb_q;
	logic                           neg_q;
	logic [W-1:0]                   ma;
	logic [W-1:0]                   mb;
	logic [W:0]                     rem_sh;
	logic                           take;

	// Operand magnitudes; the most negative value keeps its unsigned magnitude.
	assign ma = dividend[W-1] ? W'('0 - dividend) : dividend;
	assign mb = divisor[W-1] ? W'('0 - divisor) : divisor;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign take   = rem_sh >= {1'b0, mb_q};

	// The quotient truncates toward zero and wraps at the value width.
	assign quotient = neg_q ? W'('0 - quo_q) : quo_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + rse_pkg::DIV_CNT_W'(1);
				if (cnt_q == rse_pkg::DIV_CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers of the iteration.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= ma;
			mb_q  <= mb;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - {1'b0, mb_q}) : rem_sh;
			quo_q <= {quo_q[W-2:0], take};
		end
	end

endmodule

// ===== rtl/rpn_stack_evaluator.sv =====
// Reverse Polish calculator fed one byte of expression text per beat on the
// text channel. Whitespace separates tokens; a digit token pushes its first
// digit, and a lone + - * or / combines the two top entries with wrapping
// 32-bit arithmetic and truncating division. The beat flagged end_of_expr is
// tokenized first and then closes the expression: one result beat carries the
// value or the first error, and the stack is cleared. A byte that does not
// complete an operator token, digit pushes included, is taken without a
// stall but for the final-beat hold below. A byte that completes + - or *
// stalls in EXEC, as the second stack entry is read from the registered
// stack memory while the top entry sits in a register. A byte completing /
// also waits in S_DIV on the bit-serial divider, one quotient bit per cycle;
// EXEC catches a zero divisor. A final beat is held off while the previous
// result still waits on the result channel. The stack memory needs no
// clearing after reset: only entries below the depth count are ever read.
module rpn_stack_evaluator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_stall,
	input  rse_pkg::text_beat_t   text,
	output logic                  result_valid,
	input  logic                  result_stall,
	output rse_pkg::result_beat_t result
);

	localparam int A  = rse_pkg::ADDR_W;
	localparam int D  = rse_pkg::DEPTH_W;
	localparam int VW = rse_pkg::VALUE_WIDTH;

	rse_pkg::state_t       state_q, state_d;
	logic [D-1:0]          depth_q, depth_d;
	rse_pkg::status_t      err_q, err_d;
	logic [VW-1:0]         tos_q, tos_d;
	logic                  tok_q, tok_d;
	logic [7:0]            first_q, first_d;
	logic                  long_q, long_d;
	rse_pkg::op_t          op_q, op_d;
	logic                  fin_q, fin_d;
	logic                  result_valid_q;
	rse_pkg::result_beat_t result_q;

	logic                  accept;
	logic                  sp;
	logic                  do_finish;
	logic [7:0]            tc;
	logic                  tl;
	logic [D-1:0]          depth_sub2;
	logic                  we;
	logic [A-1:0]          waddr;
	logic [VW-1:0]         wdata;
	logic                  re;
	logic [VW-1:0]         rdata;
	logic                  op_issue;
	logic                  div_start;
	logic                  div_done;
	logic [VW-1:0]         quotient;
	logic [VW-1:0]         prod;
	logic [VW-1:0]         r;
	logic                  stack_wb;
	logic                  emit;
	rse_pkg::status_t      res_status;
	logic [rse_pkg::OUT_VALUE_W-1:0] res_value;

	// Operators hold off the input side; a waiting result holds off a final beat.
	assign accept     = text_valid && !text_stall;
	assign text_stall = (state_q != rse_pkg::S_IDLE) || (text.end_of_expr && result_valid_q);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Token boundaries and the token being finished by this byte.
	assign sp         = rse_pkg::is_space(text.char_in);
	assign do_finish  = sp ? tok_q : text.end_of_expr;
	assign tc         = (sp || tok_q) ? first_q : text.char_in;
	assign tl         = sp ? long_q : tok_q;
	assign depth_sub2 = depth_q - D'(2);

	// Operand a comes from memory, operand b is the registered top of stack.
	assign prod = VW'(rdata * tos_q);

	rse_stack_mem #(
		.Depth(rse_pkg::STACK_DEPTH),
		.Width(VW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(depth_sub2[A-1:0]),
		.rdata(rdata)
	);

	rse_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rdata),
		.divisor (tos_q),
		.done    (div_done),
		.quotient(quotient)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rse_pkg::S_IDLE: begin
				if (op_issue) begin
					state_d = rse_pkg::S_EXEC;
				end
			end
			rse_pkg::S_EXEC: begin
				state_d = div_start ? rse_pkg::S_DIV : rse_pkg::S_IDLE;
			end
			rse_pkg::S_DIV: begin
				if (div_done) begin
					state_d = rse_pkg::S_IDLE;
				end
			end
			default: state_d = rse_pkg::S_IDLE;
		endcase
	end

	// Tokenizer, stack update and result formation.
	always_comb begin
		depth_d   = depth_q;
		err_d     = err_q;
		tos_d     = tos_q;
		tok_d     = tok_q;
		first_d   = first_q;
		long_d    = long_q;
		op_d      = op_q;
		fin_d     = fin_q;
		we        = 1'b0;
		waddr     = depth_q[A-1:0];
		wdata     = tos_q;
		re        = 1'b0;
		op_issue  = 1'b0;
		div_start = 1'b0;
		stack_wb  = 1'b0;
		emit      = 1'b0;
		r         = '0;
		case (state_q)
			rse_pkg::S_IDLE: begin
				if (accept) begin
					// Track the current token.
					if (sp) begin
						tok_d = 1'b0;
					end else if (!tok_q) begin
						tok_d   = 1'b1;
						first_d = text.char_in;
						long_d  = 1'b0;
					end else begin
						long_d = 1'b1;
					end
					// Act on a completed token unless an error is already held.
					if (do_finish && err_q == rse_pkg::ST_OK) begin
						if (!tl && (tc == rse_pkg::CH_LPAREN || tc == rse_pkg::CH_RPAREN)) begin
							err_d = rse_pkg::ST_PAREN;
						end else if (tc inside {[rse_pkg::CH_ZERO:rse_pkg::CH_NINE]}) begin
							if (depth_q >= D'(rse_pkg::STACK_DEPTH)) begin
								err_d = rse_pkg::ST_OVERFLOW;
							end else begin
								we      = 1'b1;
								waddr   = depth_q[A-1:0];
								wdata   = {{(VW-4){1'b0}}, tc[3:0]};
								tos_d   = {{(VW-4){1'b0}}, tc[3:0]};
								depth_d = depth_q + D'(1);
							end
						end else if (!tl && (tc inside {rse_pkg::CH_PLUS, rse_pkg::CH_MINUS,
								rse_pkg::CH_STAR, rse_pkg::CH_SLASH})) begin
							if (depth_q < D'(2)) begin
								err_d = rse_pkg::ST_FEW;
							end else begin
								re       = 1'b1;
								op_issue = 1'b1;
								case (tc)
									rse_pkg::CH_PLUS:  op_d = rse_pkg::OP_ADD;
									rse_pkg::CH_MINUS: op_d = rse_pkg::OP_SUB;
									rse_pkg::CH_STAR:  op_d = rse_pkg::OP_MUL;
									default:           op_d = rse_pkg::OP_DIV;
								endcase
							end
						end else begin
							err_d = rse_pkg::ST_INVALID;
						end
					end
					// The final byte closes the expression.
					fin_d = text.end_of_expr;
					if (text.end_of_expr) begin
						tok_d   = 1'b0;
						first_d = '0;
						long_d  = 1'b0;
						emit    = !op_issue;
					end
				end
			end
			rse_pkg::S_EXEC: begin
				case (op_q)
					rse_pkg::OP_ADD: r = rdata + tos_q;
					rse_pkg::OP_SUB: r = rdata - tos_q;
					rse_pkg::OP_MUL: r = prod;
					default:         r = quotient;
				endcase
				if (op_q == rse_pkg::OP_DIV) begin
					if (tos_q == '0) begin
						err_d = rse_pkg::ST_DIV0;
						emit  = fin_q;
					end else begin
						div_start = 1'b1;
					end
				end else begin
					stack_wb = 1'b1;
					emit     = fin_q;
				end
			end
			rse_pkg::S_DIV: begin
				r = quotient;
				if (div_done) begin
					stack_wb = 1'b1;
					emit     = fin_q;
				end
			end
			default: ;
		endcase

		// Operator result replaces the two top entries.
		if (stack_wb) begin
			we      = 1'b1;
			waddr   = depth_sub2[A-1:0];
			wdata   = r;
			tos_d   = r;
			depth_d = depth_q - D'(1);
		end

		// Closing status: first error, else a depth check.
		if (err_d != rse_pkg::ST_OK) begin
			res_status = err_d;
		end else if (depth_d != D'(1)) begin
			res_status = rse_pkg::ST_DEPTH;
		end else begin
			res_status = rse_pkg::ST_OK;
		end
		res_value = (res_status == rse_pkg::ST_OK) ? rse_pkg::OUT_VALUE_W'(tos_d) : '0;
		if (emit) begin
			depth_d = '0;
			err_d   = rse_pkg::ST_OK;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rse_pkg::S_IDLE;
			depth_q <= '0;
			err_q   <= rse_pkg::ST_OK;
			tok_q   <= 1'b0;
			first_q <= '0;
			long_q  <= 1'b0;
			op_q    <= rse_pkg::OP_ADD;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			err_q   <= err_d;
			tok_q   <= tok_d;
			first_q <= first_d;
			long_q  <= long_d;
			op_q    <= op_d;
			fin_q   <= fin_d;
		end
	end

	// Top-of-stack copy.
	always_ff @(posedge clk) begin
		tos_q <= tos_d;
	end

	// Result output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.value  <= res_value;
			result_q.status <= res_status;
		end
	end

endmodule

// ===== rtl/rse_checker.sv =====
`include "assert_macros.svh"

module rse_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  text_valid,
	input logic                  text_stall,
	input rse_pkg::text_beat_t   text,
	input logic                  result_valid,
	input logic                  result_stall,
	input rse_pkg::result_beat_t result
);

	// A waiting result beat stays put until it is taken.
	`ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

	// An error result never carries a value.
	`ASSERT_ALWAYS(a_err_value_zero, !result_valid || result.status == rse_pkg::ST_OK || result.value == '0)

	// A final beat is held off while an earlier result has not been taken.
	`ASSERT_ALWAYS(a_final_held, !(text_valid && text.end_of_expr && result_valid) || text_stall)

	// Only a final beat can raise a result in the following cycle.
	`ASSERT_NEXT(a_no_spurious, text_valid && !text_stall && !text.end_of_expr, !$rose(result_valid))

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int VW             = rse_pkg::VALUE_WIDTH;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  text_valid   = 1'b0;
	logic                  text_stall;
	rse_pkg::text_beat_t   text         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	rse_pkg::result_beat_t result;

	rpn_stack_evaluator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text         (text),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Calculator state as the predictor sees it.
	logic [VW-1:0]          calc_stack [rse_pkg::STACK_DEPTH];
	int                     calc_depth    = 0;
	bit                     calc_in_token = 1'b0;
	logic [7:0]             calc_first    = '0;
	bit                     calc_long     = 1'b0;
	rse_pkg::status_t       calc_err      = rse_pkg::ST_OK;

	rse_pkg::result_beat_t awaited_results [$];
	logic [7:0]   text_buf [$];
	int           fail_count   = 0;
	int           idle_cycles  = 0;
	int           stall_hold   = 0;
	int           no_gap_run   = 0;

	function automatic bit is_blank(logic [7:0] c);
		return (c == rse_pkg::CH_SPACE) || (c >= rse_pkg::CH_TAB && c <= rse_pkg::CH_CR);
	endfunction

	// Close the current token: push a digit, apply an operator or latch an error.
	function automatic void close_token();
		logic [VW-1:0] lhs, rhs, res, mag_l, mag_r, quot;
		bit lone;
		lone = !calc_long;
		if (calc_err != rse_pkg::ST_OK)
			return;
		if (lone && (calc_first == rse_pkg::CH_LPAREN || calc_first == rse_pkg::CH_RPAREN)) begin
			calc_err = rse_pkg::ST_PAREN;
		end else if (calc_first >= rse_pkg::CH_ZERO && calc_first <= rse_pkg::CH_NINE) begin
			if (calc_depth >= rse_pkg::STACK_DEPTH) begin
				calc_err = rse_pkg::ST_OVERFLOW;
			end else begin
				calc_stack[calc_depth] = VW'(calc_first - rse_pkg::CH_ZERO);
				calc_depth++;
			end
		end else if (lone && (calc_first == rse_pkg::CH_PLUS || calc_first == rse_pkg::CH_MINUS ||
				calc_first == rse_pkg::CH_STAR || calc_first == rse_pkg::CH_SLASH)) begin
			if (calc_depth < 2) begin
				calc_err = rse_pkg::ST_FEW;
				return;
			end
			rhs = calc_stack[calc_depth - 1];
			lhs = calc_stack[calc_depth - 2];
			case (calc_first)
				rse_pkg::CH_PLUS:  res = lhs + rhs;
				rse_pkg::CH_MINUS: res = lhs - rhs;
				rse_pkg::CH_STAR:  res = lhs * rhs;
				default: begin
					if (rhs == '0) begin
						calc_err = rse_pkg::ST_DIV0;
						return;
					end
					// Divide magnitudes, then restore the sign: truncates toward zero
					// and lets the most negative value over -1 wrap to itself.
					mag_l = lhs[VW-1] ? -lhs : lhs;
					mag_r = rhs[VW-1] ? -rhs : rhs;
					quot  = mag_l / mag_r;
					res   = (lhs[VW-1] ^ rhs[VW-1]) ? -quot : quot;
				end
			endcase
			calc_depth--;
			calc_stack[calc_depth - 1] = res;
		end else begin
			calc_err = rse_pkg::ST_INVALID;
		end
	endfunction

	// Advance the predictor by one accepted text beat.
	function automatic void eval_byte(logic [7:0] c, logic last);
		rse_pkg::result_beat_t res;
		if (is_blank(c)) begin
			if (calc_in_token)
				close_token();
			calc_in_token = 1'b0;
		end else if (!calc_in_token) begin
			calc_in_token = 1'b1;
			calc_first    = c;
			calc_long     = 1'b0;
		end else begin
			calc_long = 1'b1;
		end
		if (!last)
			return;
		if (calc_in_token)
			close_token();
		if (calc_err == rse_pkg::ST_OK && calc_depth != 1)
			calc_err = rse_pkg::ST_DEPTH;
		res.value  = (calc_err == rse_pkg::ST_OK) ? rse_pkg::OUT_VALUE_W'(calc_stack[0]) : '0;
		res.status = calc_err;
		awaited_results.push_back(res);
		calc_depth    = 0;
		calc_in_token = 1'b0;
		calc_first    = '0;
		calc_long     = 1'b0;
		calc_err      = rse_pkg::ST_OK;
	endfunction

	// Sender idle time: mostly none or short, sometimes long, with gap-free runs.
	function automatic int pick_gap();
		int roll;
		if (no_gap_run > 0) begin
			no_gap_run--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			no_gap_run = $urandom_range(10, 30);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(15, 40);
	endfunction

	// Drive one text beat and hold it until accepted.
	task automatic send_byte(input logic [7:0] c, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid       <= 1'b1;
		text.char_in     <= c;
		text.end_of_expr <= last;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		eval_byte(c, last);
	endtask

	// Send the buffered expression, flagging its final byte.
	task automatic flush_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endfunction

	function automatic logic [7:0] any_nonblank();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_blank(c));
		return c;
	endfunction

	function automatic logic [7:0] op_char(int k);
		case (k)
			0:       return rse_pkg::CH_PLUS;
			1:       return rse_pkg::CH_MINUS;
			2:       return rse_pkg::CH_STAR;
			default: return rse_pkg::CH_SLASH;
		endcase
	endfunction

	function automatic void add_blank();
		int n;
		if ($urandom_range(0, 9) < 7) begin
			text_buf.push_back(rse_pkg::CH_SPACE);
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0)
					text_buf.push_back(rse_pkg::CH_SPACE);
				else
					text_buf.push_back(8'($urandom_range(rse_pkg::CH_TAB, rse_pkg::CH_CR)));
			end
		end
	endfunction

	// A digit token, sometimes with trailing bytes that the block ignores.
	function automatic void add_digit();
		text_buf.push_back(rse_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) text_buf.push_back(any_nonblank());
		add_blank();
	endfunction

	// A bare digit followed by one space.
	function automatic void add_short_digit();
		text_buf.push_back(rse_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		text_buf.push_back(rse_pkg::CH_SPACE);
	endfunction

	function automatic void add_op();
		text_buf.push_back(op_char($urandom_range(0, 3)));
		add_blank();
	endfunction

	// A token that breaks an otherwise well-formed expression.
	function automatic void add_defect();
		case ($urandom_range(0, 4))
			0: begin
				text_buf.push_back(any_nonblank());
				if ($urandom_range(0, 1))
					text_buf.push_back(any_nonblank());
			end
			1: text_buf.push_back($urandom_range(0, 1) ? rse_pkg::CH_LPAREN : rse_pkg::CH_RPAREN);
			2: begin
				text_buf.push_back($urandom_range(0, 1) ? rse_pkg::CH_LPAREN : rse_pkg::CH_RPAREN);
				text_buf.push_back(any_nonblank());
			end
			3: text_buf.push_back(op_char($urandom_range(0, 3)));
			default: text_buf.push_back(rse_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		endcase
		add_blank();
	endfunction

	// Build an expression that reduces to one value, optionally with defects.
	// With pile_first all digits come before any operator.
	function automatic void build_expr(int pushes, bit pile_first, bit broken);
		int pushed, depth;
		pushed = 0;
		depth  = 0;
		if ($urandom_range(0, 3) == 0)
			add_blank();
		while (pushed < pushes || depth > 1) begin
			if (broken && $urandom_range(0, 4) == 0)
				add_defect();
			if (pushed < pushes && (depth < 2 || pile_first || $urandom_range(0, 1))) begin
				add_digit();
				pushed++;
				depth++;
			end else begin
				add_op();
				depth--;
			end
		end
		// Half the time the final beat is the last byte of the last token.
		if ($urandom_range(0, 1))
			while (text_buf.size() > 1 && is_blank(text_buf[$]))
				void'(text_buf.pop_back());
	endfunction

	// Result channel stall pattern: open stretches, short stalls, a few long ones.
	always @(posedge clk) begin
		int roll;
		if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			roll = $urandom_range(0, 9);
			if (roll < 4) begin
				result_stall <= 1'b0;
				stall_hold = $urandom_range(1, 30);
			end else if (roll < 9) begin
				result_stall <= 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else begin
				result_stall <= 1'b1;
				stall_hold = $urandom_range(20, 60);
			end
		end
	end

	// Compare every accepted result beat with the oldest prediction.
	always @(posedge clk) begin
		rse_pkg::result_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result: value %0d status %0d",
					$time, result.value, result.status);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (result.value !== want.value) begin
					$display("%0t: value mismatch: expected %0d, actual %0d",
						$time, want.value, result.value);
					fail_count++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, result.status);
					fail_count++;
				end
			end
		end
	end

	// End the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Single-byte expressions: byte extremes, parentheses, lone operator, empty.
	task automatic test_lone_bytes();
		text_buf.push_back(8'h00);
		flush_text();
		text_buf.push_back(8'hFF);
		flush_text();
		queue_text("(");
		flush_text();
		queue_text(")");
		flush_text();
		queue_text("+");
		flush_text();
		queue_text(" ");
		flush_text();
	endtask

	// All four operators in one chain.
	task automatic test_operators();
		queue_text("9 4 + 3 * 7 - 2 /");
		flush_text();
	endtask

	// Zero divisor and a final depth of two.
	task automatic test_bad_endings();
		queue_text("5 0 /");
		flush_text();
		queue_text("1 2");
		flush_text();
	endtask

	// Truncation toward zero, and the most negative value over -1.
	task automatic test_division();
		queue_text("7 0 3 - /");
		flush_text();
		queue_text("0 7 - 2 /");
		flush_text();
		queue_text("2");
		repeat (10) queue_text(" 8 *");
		queue_text(" 0 1 - /");
		flush_text();
	endtask

	// Fill the stack exactly and combine the two top entries, then push one
	// digit too many.
	task automatic test_stack_limits();
		repeat (rse_pkg::STACK_DEPTH) add_short_digit();
		text_buf.push_back(op_char($urandom_range(0, 2)));
		flush_text();
		repeat (rse_pkg::STACK_DEPTH + 1) add_short_digit();
		flush_text();
	endtask

	// Random well-formed expressions, some with defects.
	task automatic test_random_exprs();
		int sent;
		sent = 0;
		while (sent < 80) begin
			if ($urandom_range(0, 11) == 0)
				build_expr($urandom_range(8, 30), 1'b0, $urandom_range(0, 4) == 0);
			else
				build_expr($urandom_range(1, 8), 1'b0, $urandom_range(0, 4) == 0);
			sent += text_buf.size();
			flush_text();
		end
	endtask

	// Raw random bytes cut into short expressions.
	task automatic test_noise();
		int n;
		repeat (6) begin
			n = $urandom_range(1, 8);
			repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
			flush_text();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lone_bytes();
		test_operators();
		test_bad_endings();
		test_division();
		test_stack_limits();
		test_random_exprs();
		test_noise();

		text_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
